FILE: sv/t2dfl_pkg.sv
package t2dfl_pkg;

   localparam logic signed [31:0] Q16_ONE         = 32'sh0001_0000;
   localparam logic signed [31:0] NOT_FOUND_VALUE = 32'sd666;

   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_STORED    = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] row_key;
      logic signed [31:0] col_key;
      logic signed [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] lookup_value;
      logic [1:0]         status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic decode;
      logic scan_start;
      logic rd_issue;
      logic pass2;
      logic clamp;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_query;
      logic count_zero;
      logic addr_last;
      logic rsp_free;
   } stat_type;

endpackage

FILE: sv/t2dfl_ctrl.sv
module t2dfl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  t2dfl_pkg::stat_type stat_i,
   output t2dfl_pkg::cmd_type  cmd_o
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SCAN1, S_WAIT1, S_CLAMP, S_SCAN2, S_WAIT2, S_FINISH
   } state_type;

   state_type state_ff;
   logic      stall_ff;
   logic      accept;

   assign req_stall = stall_ff;
   assign accept    = req_valid && !stall_ff;

   always_comb begin
      cmd_o            = '0;
      cmd_o.capture    = accept;
      cmd_o.decode     = (state_ff == S_DECODE);
      cmd_o.scan_start = (state_ff == S_DECODE) || (state_ff == S_CLAMP);
      cmd_o.rd_issue   = (state_ff == S_SCAN1) || (state_ff == S_SCAN2);
      cmd_o.pass2      = (state_ff == S_SCAN2);
      cmd_o.clamp      = (state_ff == S_CLAMP);
      cmd_o.finish     = (state_ff == S_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_DECODE;
                  stall_ff <= 1'b1;
               end
            end
            S_DECODE: begin
               if (stat_i.is_query && !stat_i.count_zero) begin
                  state_ff <= S_SCAN1;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_SCAN1: begin
               if (stat_i.addr_last) begin
                  state_ff <= S_WAIT1;
               end
            end
            S_WAIT1: state_ff <= S_CLAMP;
            S_CLAMP: state_ff <= S_SCAN2;
            S_SCAN2: begin
               if (stat_i.addr_last) begin
                  state_ff <= S_WAIT2;
               end
            end
            S_WAIT2: state_ff <= S_FINISH;
            S_FINISH: begin
               if (stat_i.rsp_free) begin
                  state_ff <= S_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: sv/t2dfl_datapath.sv
module t2dfl_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  t2dfl_pkg::req_type  req_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output t2dfl_pkg::rsp_type  rsp_data,
   input  t2dfl_pkg::cmd_type  cmd_i,
   output t2dfl_pkg::stat_type stat_o
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic signed [31:0] row_mem [TABLE_DEPTH];
   logic signed [31:0] col_mem [TABLE_DEPTH];
   logic signed [31:0] val_mem [TABLE_DEPTH];

   t2dfl_pkg::req_type req_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      addr_ff;
   logic               full;

   logic               rd_vld_ff, rd_first_ff, rd_pass2_ff;
   logic signed [31:0] rd_row_ff, rd_col_ff, rd_val_ff;
   logic signed [31:0] prev_row_ff, prev_col_ff;
   logic signed [31:0] lo_row_ff, hi_row_ff, lo_col_ff, hi_col_ff;
   logic signed [31:0] brow_ff, bcol_ff;
   logic               row_open_ff, col_open_ff;
   logic signed [31:0] res_value_ff;
   logic [1:0]         res_status_ff;

   logic               rsp_valid_ff;
   t2dfl_pkg::rsp_type rsp_ff;

   assign full      = (count_ff == CW'(TABLE_DEPTH));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat_o.is_query   = (req_ff.opcode == t2dfl_pkg::OP_QUERY);
   assign stat_o.count_zero = (count_ff == '0);
   assign stat_o.addr_last  = (addr_ff == count_ff - CW'(1));
   assign stat_o.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Table storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd_i.decode && (req_ff.opcode == t2dfl_pkg::OP_APPEND) && !full) begin
         row_mem[count_ff[AW-1:0]] <= req_ff.row_key;
         col_mem[count_ff[AW-1:0]] <= req_ff.col_key;
         val_mem[count_ff[AW-1:0]] <= req_ff.entry_value;
      end
      if (cmd_i.rd_issue) begin
         rd_row_ff <= row_mem[addr_ff[AW-1:0]];
         rd_col_ff <= col_mem[addr_ff[AW-1:0]];
         rd_val_ff <= val_mem[addr_ff[AW-1:0]];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd_i.rd_issue;
         if (cmd_i.decode && (req_ff.opcode == t2dfl_pkg::OP_APPEND) && !full) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd_i.finish && stat_o.rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan datapath.
   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         req_ff <= req_data;
      end

      if (cmd_i.scan_start) begin
         addr_ff <= '0;
      end else if (cmd_i.rd_issue) begin
         addr_ff <= addr_ff + CW'(1);
      end
      rd_first_ff <= (addr_ff == '0);
      rd_pass2_ff <= cmd_i.pass2;

      if (cmd_i.decode) begin
         brow_ff     <= t2dfl_pkg::Q16_ONE;
         bcol_ff     <= t2dfl_pkg::Q16_ONE;
         row_open_ff <= 1'b1;
         col_open_ff <= 1'b1;
         if (req_ff.opcode == t2dfl_pkg::OP_QUERY) begin
            res_value_ff  <= t2dfl_pkg::NOT_FOUND_VALUE;
            res_status_ff <= t2dfl_pkg::ST_NOT_FOUND;
         end else begin
            res_value_ff  <= '0;
            res_status_ff <= full ? t2dfl_pkg::ST_FULL : t2dfl_pkg::ST_STORED;
         end
      end

      // First pass: adjacent-pair breakpoints and key bounds.
      if (rd_vld_ff && !rd_pass2_ff) begin
         prev_row_ff <= rd_row_ff;
         prev_col_ff <= rd_col_ff;
         if (rd_first_ff) begin
            lo_row_ff <= rd_row_ff;
            hi_row_ff <= rd_row_ff;
            lo_col_ff <= rd_col_ff;
            hi_col_ff <= rd_col_ff;
         end else begin
            if (row_open_ff && (prev_row_ff <= req_ff.row_key)
                && (rd_row_ff > req_ff.row_key)) begin
               brow_ff     <= prev_row_ff;
               row_open_ff <= 1'b0;
            end
            if (col_open_ff && (prev_col_ff <= req_ff.col_key)
                && (rd_col_ff > req_ff.col_key)) begin
               bcol_ff     <= prev_col_ff;
               col_open_ff <= 1'b0;
            end
            if (rd_row_ff < lo_row_ff) lo_row_ff <= rd_row_ff;
            if (rd_row_ff > hi_row_ff) hi_row_ff <= rd_row_ff;
            if (rd_col_ff < lo_col_ff) lo_col_ff <= rd_col_ff;
            if (rd_col_ff > hi_col_ff) hi_col_ff <= rd_col_ff;
         end
      end

      // Clamp to the bounds; the high bound wins. A key strictly inside the
      // bounds keeps the breakpoint from the first pass.
      if (cmd_i.clamp) begin
         priority if (req_ff.row_key >= hi_row_ff) brow_ff <= hi_row_ff;
         else if (req_ff.row_key <= lo_row_ff)      brow_ff <= lo_row_ff;
         else                                       brow_ff <= brow_ff;
         priority if (req_ff.col_key >= hi_col_ff) bcol_ff <= hi_col_ff;
         else if (req_ff.col_key <= lo_col_ff)      bcol_ff <= lo_col_ff;
         else                                       bcol_ff <= bcol_ff;
      end

      // Second pass: first entry matching both breakpoints.
      if (rd_vld_ff && rd_pass2_ff && (res_status_ff != t2dfl_pkg::ST_FOUND)
          && (rd_row_ff == brow_ff) && (rd_col_ff == bcol_ff)) begin
         res_value_ff  <= rd_val_ff;
         res_status_ff <= t2dfl_pkg::ST_FOUND;
      end

      if (cmd_i.finish && stat_o.rsp_free) begin
         rsp_ff.lookup_value <= res_value_ff;
         rsp_ff.status       <= res_status_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd_i.rd_issue |-> (addr_ff < count_ff))
      else $error("read beyond stored entries");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.decode && (req_ff.opcode == t2dfl_pkg::OP_APPEND) && !full)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("append did not advance the entry count");

   a_rd_follows_issue: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(cmd_i.rd_issue))
      else $error("read data valid without a read");

endmodule

FILE: sv/table_2d_floor_lookup.sv
// An append, or a query on an empty table, passes the decode and finish states;
// a query on stored entries passes decode, scan, wait, clamp, scan, wait, finish.
// A new request is taken only after the last leaves finish, which waits for a free
// response register. A query scans twice through the entry memory's one read port.
// Reset (synchronous, active high) empties the table and clears the handshakes;
// entry memory contents are not cleared and no clearing pass is needed.
module table_2d_floor_lookup #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  t2dfl_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output t2dfl_pkg::rsp_type rsp_data
);

   // The controller sequences each request: decode, then for a query a first
   // scan that finds the floor breakpoints and key bounds, a clamp step, and a
   // second scan for the first entry matching both breakpoints.
   t2dfl_pkg::cmd_type  cmd;
   t2dfl_pkg::stat_type stat;

   // A request is accepted whenever the controller is idle, even while the
   // previous response still waits in the output register; the new response
   // is held in the finish step until that register frees up.
   t2dfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   // The datapath holds the entry memories, entry count, scan registers and
   // the response register.
   t2dfl_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd_i     (cmd),
      .stat_o    (stat)
   );

endmodule

FILE: tb/table_2d_floor_lookup_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the entry table and predicts
// the response for every accepted request.
module table_2d_floor_lookup_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  t2dfl_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  t2dfl_pkg::rsp_type rsp_data,
   output int                 failures,
   output int                 pending
);

   logic signed [31:0] row_keys [TABLE_DEPTH];
   logic signed [31:0] col_keys [TABLE_DEPTH];
   logic signed [31:0] values   [TABLE_DEPTH];
   int                 stored = 0;
   int                 fail_count = 0;
   int                 queued = 0;
   t2dfl_pkg::rsp_type expected_q [$];

   assign failures = fail_count;
   assign pending  = queued;

   // Floor breakpoints over adjacent entries, clamp to the key bounds with the
   // high bound applied last, then the first entry that matches both breakpoints.
   function automatic t2dfl_pkg::rsp_type floor_lookup(logic signed [31:0] rk,
                                                       logic signed [31:0] ck);
      t2dfl_pkg::rsp_type res;
      logic signed [31:0] brow, bcol, lo_r, hi_r, lo_c, hi_c;
      bit                 row_open, col_open;
      res.lookup_value = t2dfl_pkg::NOT_FOUND_VALUE;
      res.status       = t2dfl_pkg::ST_NOT_FOUND;
      if (stored == 0) begin
         return res;
      end
      brow     = t2dfl_pkg::Q16_ONE;
      bcol     = t2dfl_pkg::Q16_ONE;
      row_open = 1'b1;
      col_open = 1'b1;
      lo_r     = row_keys[0];
      hi_r     = row_keys[0];
      lo_c     = col_keys[0];
      hi_c     = col_keys[0];
      for (int i = 0; i < stored; i++) begin
         if (i + 1 < stored) begin
            if (row_open && row_keys[i] <= rk && row_keys[i + 1] > rk) begin
               brow     = row_keys[i];
               row_open = 1'b0;
            end
            if (col_open && col_keys[i] <= ck && col_keys[i + 1] > ck) begin
               bcol     = col_keys[i];
               col_open = 1'b0;
            end
         end
         if (row_keys[i] < lo_r) lo_r = row_keys[i];
         if (col_keys[i] < lo_c) lo_c = col_keys[i];
         if (row_keys[i] > hi_r) hi_r = row_keys[i];
         if (col_keys[i] > hi_c) hi_c = col_keys[i];
      end
      if (rk <= lo_r) brow = lo_r;
      if (ck <= lo_c) bcol = lo_c;
      if (rk >= hi_r) brow = hi_r;
      if (ck >= hi_c) bcol = hi_c;
      for (int i = 0; i < stored; i++) begin
         if (row_keys[i] == brow && col_keys[i] == bcol) begin
            res.lookup_value = values[i];
            res.status       = t2dfl_pkg::ST_FOUND;
            return res;
         end
      end
      return res;
   endfunction

   // Applies one request to the table copy and returns its response.
   function automatic t2dfl_pkg::rsp_type accept_request(t2dfl_pkg::req_type r);
      t2dfl_pkg::rsp_type res;
      if (r.opcode == t2dfl_pkg::OP_QUERY) begin
         return floor_lookup(r.row_key, r.col_key);
      end
      res.lookup_value = '0;
      if (stored < TABLE_DEPTH) begin
         row_keys[stored] = r.row_key;
         col_keys[stored] = r.col_key;
         values[stored]   = r.entry_value;
         stored++;
         res.status = t2dfl_pkg::ST_STORED;
      end else begin
         res.status = t2dfl_pkg::ST_FULL;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      t2dfl_pkg::rsp_type got, want;
      if (reset) begin
         stored = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_q.size() == 0) begin
               $error("response with none outstanding: lookup_value %0d status %0d",
                      got.lookup_value, got.status);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.lookup_value !== want.lookup_value) begin
                  $error("lookup_value: expected %0d, got %0d",
                         want.lookup_value, got.lookup_value);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_q.insert(expected_q.size(), accept_request(req_data));
         end
      end
      queued <= expected_q.size();
   end

endmodule

FILE: tb/table_2d_floor_lookup_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the two-dimensional floor lookup table. The checker
// beside the block predicts and compares every response; this module only
// produces requests, paces the response side and decides pass or fail.
module table_2d_floor_lookup_test;

   localparam int DEPTH        = 256;
   localparam int RANDOM_ITEMS = 600;
   // The limit is sized for the slowest correct run, in which every item is a query
   // over a full table, and leaves ample margin.
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int HOLD_CYCLES  = 1500;
   localparam int TAIL_CYCLES  = 2 * DEPTH + 16;

   localparam logic signed [31:0] KEY_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX  = 32'sh7fff_ffff;
   // Grids are built above this key so that the directed entries, whose
   // adjacent pairs all descend, never capture a breakpoint inside a grid.
   localparam logic signed [31:0] KEY_BASE = 32'sh0002_0000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   t2dfl_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   t2dfl_pkg::rsp_type rsp_data;

   int failures;
   int pending;
   int sent = 0;
   int received = 0;
   int appended = 0;

   // The most recent grid of entries, kept so that queries can aim at its keys.
   logic signed [31:0] grid_rows [4];
   logic signed [31:0] grid_cols [5];
   int                 grid_nrows = 1;
   int                 grid_ncols = 1;
   logic signed [31:0] row_floor = KEY_BASE;
   logic signed [31:0] col_floor = KEY_BASE;

   table_2d_floor_lookup #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   table_2d_floor_lookup_checker #(
      .TABLE_DEPTH(DEPTH)
   ) lookup_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   initial forever #6 clock = ~clock;

   // Watchdog: a run that has not finished by the cycle limit has hung.
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL table_2d_floor_lookup");
      $finish;
   end

   // Idle cycles before the next request or response. Every fourth stretch
   // of forty runs without any idling so that back-to-back traffic is seen.
   function automatic int idle_draw(int count);
      if ((count / 40) % 4 == 3) begin
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   // Query key aimed at a grid: an exact stored key, a key in or just around
   // the grid, a key anywhere in the stored range, or a fully random key.
   function automatic logic signed [31:0] aim_key(logic signed [31:0] exact,
                                                  logic signed [31:0] lo,
                                                  logic signed [31:0] hi);
      unique case ($urandom_range(0, 4))
         0, 1:    return exact;
         2:       return lo - 32'sh0001_0000 + $urandom_range(0, hi - lo + 32'h3_0000);
         3:       return KEY_BASE + $urandom_range(0, hi - KEY_BASE);
         default: return $urandom;
      endcase
   endfunction

   // Offers one request after a random gap and holds it until accepted. Valid
   // stays high into the next request when there is no gap, so it is never
   // lowered and raised in the same step.
   task automatic offer(input logic op, input logic signed [31:0] rk,
                        input logic signed [31:0] ck, input logic signed [31:0] val);
      t2dfl_pkg::req_type item;
      int                 gap;
      item.opcode      = op;
      item.row_key     = rk;
      item.col_key     = ck;
      item.entry_value = val;
      gap = idle_draw(sent);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (op == t2dfl_pkg::OP_APPEND) appended++;
   endtask

   // Drops valid and waits until every predicted response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Response side: a random stall before each response, and once a long
   // hold-off while requests keep coming, so the block fills and stalls its
   // input.
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_draw(received);
         if (!held && received == 200) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         received++;
      end
   end

   initial begin
      int random_start;
      int episode;
      int nq;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A query on the empty table is not found.
      offer(t2dfl_pkg::OP_QUERY, KEY_MIN, KEY_MAX, $urandom);
      // With a single entry the pair scan finds nothing and the clamp picks it.
      offer(t2dfl_pkg::OP_APPEND, KEY_MAX, KEY_MAX, KEY_MAX);
      offer(t2dfl_pkg::OP_QUERY, 32'sd0, 32'sd0, $urandom);
      offer(t2dfl_pkg::OP_QUERY, KEY_MAX, KEY_MAX, $urandom);
      // A descending pair leaves both breakpoints at their 1.0 default, and
      // an entry keyed 1.0 makes that default match.
      offer(t2dfl_pkg::OP_APPEND, t2dfl_pkg::Q16_ONE, t2dfl_pkg::Q16_ONE, KEY_MIN);
      offer(t2dfl_pkg::OP_QUERY, 32'sh0002_0000, 32'sh0002_0000, $urandom);
      offer(t2dfl_pkg::OP_APPEND, KEY_MIN, KEY_MIN, 32'sd0);
      // Row clamped to the low bound, column to the high bound: no such entry.
      offer(t2dfl_pkg::OP_QUERY, KEY_MIN, KEY_MAX, $urandom);
      offer(t2dfl_pkg::OP_QUERY, KEY_MAX, KEY_MIN, $urandom);
      offer(t2dfl_pkg::OP_QUERY, KEY_MIN, KEY_MIN, $urandom);
      offer(t2dfl_pkg::OP_QUERY, 32'sd0, 32'sd0, $urandom);
      offer(t2dfl_pkg::OP_QUERY, -32'sd1, -32'sd1, KEY_MAX);
      offer(t2dfl_pkg::OP_QUERY, t2dfl_pkg::Q16_ONE, t2dfl_pkg::Q16_ONE, KEY_MIN);
      // The sender pauses here until every response has arrived.
      wait_drained();

      // Random part: mostly row-major grids with ascending keys followed by
      // queries aimed at them, plus noise. Once the table is full, appends
      // are dropped and queries keep probing the stored range.
      random_start = sent;
      episode      = 0;
      while (sent - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            // Noise: negative-key appends go in ahead of the next grid, below all of
            // its keys; random queries land anywhere.
            if ($urandom_range(0, 1) == 1) begin
               offer(t2dfl_pkg::OP_APPEND, {1'b1, 31'($urandom)},
                     {1'b1, 31'($urandom)}, $urandom);
            end else begin
               offer(t2dfl_pkg::OP_QUERY, $urandom, $urandom, $urandom);
            end
         end
         if (appended < DEPTH) begin
            grid_nrows = $urandom_range(1, 4);
            grid_ncols = $urandom_range(1, 5);
            for (int r = 0; r < grid_nrows; r++) begin
               grid_rows[r] = (r == 0 ? row_floor : grid_rows[r - 1])
                              + $urandom_range(1, 32'h3_ffff);
            end
            for (int c = 0; c < grid_ncols; c++) begin
               grid_cols[c] = (c == 0 ? col_floor : grid_cols[c - 1])
                              + $urandom_range(1, 32'h3_ffff);
            end
            for (int r = 0; r < grid_nrows; r++) begin
               for (int c = 0; c < grid_ncols; c++) begin
                  offer(t2dfl_pkg::OP_APPEND, grid_rows[r], grid_cols[c], $urandom);
               end
            end
            row_floor = grid_rows[grid_nrows - 1];
            col_floor = grid_cols[grid_ncols - 1];
         end else begin
            // The table is full, so this entry is dropped.
            offer(t2dfl_pkg::OP_APPEND, $urandom, $urandom, $urandom);
         end
         nq = $urandom_range(2, 8);
         for (int q = 0; q < nq; q++) begin
            offer(t2dfl_pkg::OP_QUERY,
                  aim_key(grid_rows[$urandom_range(0, grid_nrows - 1)], grid_rows[0], row_floor),
                  aim_key(grid_cols[$urandom_range(0, grid_ncols - 1)], grid_cols[0], col_floor),
                  $urandom);
         end
         episode++;
         if (episode == 20) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("PASS table_2d_floor_lookup");
      end else begin
         $display("FAIL table_2d_floor_lookup");
      end
      $finish;
   end

endmodule

FILE: table_2d_floor_lookup.f
sv/t2dfl_pkg.sv
sv/t2dfl_ctrl.sv
sv/t2dfl_datapath.sv
sv/table_2d_floor_lookup.sv
tb/table_2d_floor_lookup_checker.sv
tb/table_2d_floor_lookup_test.sv
